// File: hw/rtl/rmsd_pkg.sv
// Shared widths, constants and controller/datapath bundles of the running mean/stdev block.
package rmsd_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 24;             // sample and mean, signed fixed point
    localparam int N_W      = 16;             // sample counts
    localparam int MAG_W    = 24;             // |sample - mean|
    localparam int SQ_W     = 2 * MAG_W;      // squared deviation
    localparam int M2_W     = 64;             // sum of squared deviations
    localparam int ROOT_W   = M2_W / 2;       // integer square root of a 64-bit value
    localparam int STD_W    = 24;             // reported standard deviation
    localparam int STEP_W   = 6;              // sequencer step counter

    // Last step index of each iterative phase
    localparam logic [STEP_W-1:0] ITEM_DIV_LAST  = STEP_W'(SQ_W - 1);
    localparam logic [STEP_W-1:0] BATCH_DIV_LAST = STEP_W'(M2_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST      = STEP_W'(ROOT_W - 1);

    // Register reset value and saturation limits
    localparam logic [N_W-1:0]   COUNT_RESET = N_W'(1000);
    localparam logic [STD_W-1:0] STD_MAX     = '1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;        // take the incoming sample
        logic calc;           // deviation magnitude, sign and new count
        logic square;         // square the deviation, load the divider for the item
        logic div_step;       // one quotient bit on both divider lanes
        logic update;         // fold the quotients into mean and m2
        logic load_batch;     // load the divider with m2 for the batch result
        logic sqrt_load;      // load the root unit with m2 / n
        logic sqrt_step;      // one root bit
        logic emit;           // fill the output register and clear the batch state
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic batch_done;     // updated count has reached the batch size
    } t_dp_sts;

endpackage

// File: hw/rtl/rmsd_div.sv
// Two-lane restoring divider by the running count, one quotient bit per step.
module rmsd_div (
    input  logic                          i_clk,
    input  logic                          i_load_item,
    input  logic                          i_load_batch,
    input  logic                          i_step,
    input  logic [rmsd_pkg::SQ_W-1:0]     i_item_sq,
    input  logic [rmsd_pkg::MAG_W-1:0]    i_item_mag,
    input  logic [rmsd_pkg::M2_W-1:0]     i_batch_m2,
    input  logic [rmsd_pkg::N_W-1:0]      i_divisor,
    output logic [rmsd_pkg::M2_W-1:0]     o_quot_a,
    output logic [rmsd_pkg::N_W-1:0]      o_rem_a,
    output logic [rmsd_pkg::MAG_W-1:0]    o_quot_b
);
    import rmsd_pkg::*;

    // Lane A: dividend left-aligned, quotient bits shift in at the bottom
    logic [M2_W-1:0]  r_a;
    logic [N_W-1:0]   r_ra;
    // Lane B: magnitude divided in step with lane A
    logic [SQ_W-1:0]  r_b;
    logic [N_W-1:0]   r_rb;

    logic [N_W:0]     w_ta;
    logic [N_W:0]     w_tb;
    logic [N_W:0]     w_div;
    logic             w_qa;
    logic             w_qb;

    // Trial subtraction on each lane
    always_comb begin
        w_div = {1'b0, i_divisor};
        w_ta  = {r_ra, r_a[M2_W-1]};
        w_tb  = {r_rb, r_b[SQ_W-1]};
        w_qa  = (w_ta >= w_div);
        w_qb  = (w_tb >= w_div);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_item) begin
            r_a  <= {i_item_sq, {(M2_W - SQ_W){1'b0}}};
            r_b  <= {i_item_mag, {(SQ_W - MAG_W){1'b0}}};
            r_ra <= '0;
            r_rb <= '0;
        end else if (i_load_batch) begin
            r_a  <= i_batch_m2;
            r_b  <= '0;
            r_ra <= '0;
            r_rb <= '0;
        end else if (i_step) begin
            r_a  <= {r_a[M2_W-2:0], w_qa};
            r_b  <= {r_b[SQ_W-2:0], w_qb};
            r_ra <= w_qa ? N_W'(w_ta - w_div) : w_ta[N_W-1:0];
            r_rb <= w_qb ? N_W'(w_tb - w_div) : w_tb[N_W-1:0];
        end
    end

    // Lane B dividend was scaled up by its zero padding; the integer quotient
    // sits in the upper half, the lower half holds fraction bits
    assign o_quot_a = r_a;
    assign o_rem_a  = r_ra;
    assign o_quot_b = r_b[SQ_W-1:MAG_W];

endmodule

// File: hw/rtl/rmsd_sqrt.sv
// Digit-by-digit integer square root, one root bit per step.
module rmsd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [rmsd_pkg::M2_W-1:0]     i_value,
    output logic [rmsd_pkg::ROOT_W-1:0]   o_root
);
    import rmsd_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [M2_W-1:0]   r_val;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;

    logic [REM_W+1:0]  w_tmp;
    logic [REM_W+1:0]  w_trial;
    logic              w_fit;

    // Bring down two bits and test root*4+1
    always_comb begin
        w_tmp   = {r_rem, r_val[M2_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_fit   = (w_tmp >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val  <= i_value;
            r_root <= '0;
            r_rem  <= '0;
        end else if (i_step) begin
            r_val  <= {r_val[M2_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], w_fit};
            r_rem  <= w_fit ? REM_W'(w_tmp - w_trial) : w_tmp[REM_W-1:0];
        end
    end

    assign o_root = r_root;

endmodule

// File: hw/rtl/rmsd_dp.sv
// Datapath: batch state, count register, divider and root units, output register.
module rmsd_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmsd_pkg::t_dp_cmd             i_cmd,
    output rmsd_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [rmsd_pkg::N_W-1:0]      i_cfg_data,
    input  logic [rmsd_pkg::SAMPLE_W-1:0] i_sample,
    output logic [rmsd_pkg::SAMPLE_W-1:0] o_mean_value,
    output logic [rmsd_pkg::STD_W-1:0]    o_std_deviation,
    output logic [rmsd_pkg::N_W-1:0]      o_batch_size
);
    import rmsd_pkg::*;

    // Configuration and batch state
    logic [N_W-1:0]      r_sample_count;
    logic [N_W-1:0]      r_seen;
    logic [SAMPLE_W-1:0] r_mean;
    logic [M2_W-1:0]     r_m2;

    // Per-item working registers
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [N_W-1:0]      r_n;
    logic [SQ_W-1:0]     r_d2;

    // Output register
    logic [SAMPLE_W-1:0] r_out_mean;
    logic [STD_W-1:0]    r_out_std;
    logic [N_W-1:0]      r_out_n;

    logic [SAMPLE_W:0]   w_diff;
    logic [SQ_W-1:0]     w_sq;
    logic [M2_W-1:0]     w_quot_a;
    logic [N_W-1:0]      w_rem_a;
    logic [MAG_W-1:0]    w_quot_b;
    logic [ROOT_W-1:0]   w_root;
    logic [SQ_W-1:0]     w_term;
    logic [M2_W:0]       w_sum;
    logic [M2_W-1:0]     n_m2;
    logic [SAMPLE_W+1:0] w_mean_ext;
    logic [SAMPLE_W+1:0] w_mean_new;
    logic [SAMPLE_W-1:0] n_mean;
    logic [N_W-1:0]      w_limit;
    logic [STD_W-1:0]    w_std;

    // Deviation and its square
    always_comb begin
        w_diff = {r_sample[SAMPLE_W-1], r_sample} - {r_mean[SAMPLE_W-1], r_mean};
        w_sq   = SQ_W'({{MAG_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, r_mag});
    end

    // m2 += d2 - ceil(d2 / n), saturating
    always_comb begin
        w_term = r_d2 - w_quot_a[SQ_W-1:0] - SQ_W'(|w_rem_a);
        w_sum  = {1'b0, r_m2} + {{(M2_W - SQ_W + 1){1'b0}}, w_term};
        n_m2   = w_sum[M2_W] ? '1 : w_sum[M2_W-1:0];
    end

    // mean += sign * (|diff| / n), clamped to the sample range
    always_comb begin
        w_mean_ext = {{2{r_mean[SAMPLE_W-1]}}, r_mean};
        w_mean_new = r_neg ? w_mean_ext - {2'b00, w_quot_b}
                           : w_mean_ext + {2'b00, w_quot_b};
        if (!w_mean_new[SAMPLE_W+1] && (w_mean_new[SAMPLE_W:SAMPLE_W-1] != 2'b00)) begin
            n_mean = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (w_mean_new[SAMPLE_W+1] &&
                     (w_mean_new[SAMPLE_W:SAMPLE_W-1] != 2'b11)) begin
            n_mean = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            n_mean = w_mean_new[SAMPLE_W-1:0];
        end
    end

    // Batch end test, a zero count acting as one; root saturated to STD_MAX
    always_comb begin
        w_limit          = (r_sample_count == '0) ? N_W'(1) : r_sample_count;
        o_sts.batch_done = (r_n >= w_limit);
        w_std            = (w_root > ROOT_W'(STD_MAX)) ? STD_MAX : w_root[STD_W-1:0];
    end

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_sample_count <= i_cfg_data;
        end
    end

    // Batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_mean <= '0;
            r_m2   <= '0;
        end else if (i_cmd.emit) begin
            r_seen <= '0;
            r_mean <= '0;
            r_m2   <= '0;
        end else if (i_cmd.update) begin
            r_seen <= r_n;
            r_mean <= n_mean;
            r_m2   <= n_m2;
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.calc) begin
            r_neg <= w_diff[SAMPLE_W];
            r_mag <= w_diff[SAMPLE_W] ? MAG_W'(-w_diff) : w_diff[MAG_W-1:0];
            r_n   <= r_seen + N_W'(1);
        end
        if (i_cmd.square) begin
            r_d2 <= w_sq;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_mean <= r_mean;
            r_out_std  <= w_std;
            r_out_n    <= r_n;
        end
    end

    rmsd_div u_div (
        .i_clk        (i_clk),
        .i_load_item  (i_cmd.square),
        .i_load_batch (i_cmd.load_batch),
        .i_step       (i_cmd.div_step),
        .i_item_sq    (w_sq),
        .i_item_mag   (r_mag),
        .i_batch_m2   (r_m2),
        .i_divisor    (r_n),
        .o_quot_a     (w_quot_a),
        .o_rem_a      (w_rem_a),
        .o_quot_b     (w_quot_b)
    );

    rmsd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_load  (i_cmd.sqrt_load),
        .i_step  (i_cmd.sqrt_step),
        .i_value (w_quot_a),
        .o_root  (w_root)
    );

    assign o_mean_value    = r_out_mean;
    assign o_std_deviation = r_out_std;
    assign o_batch_size    = r_out_n;

endmodule

// File: hw/rtl/rmsd_ctrl.sv
// Controller: sequences one item through the datapath and hands off batch results.
module rmsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rmsd_pkg::t_dp_sts i_sts,
    output rmsd_pkg::t_dp_cmd o_cmd
);
    import rmsd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CALC   = 4'd1;
    localparam logic [3:0] S_SQUARE = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_UPDATE = 4'd4;
    localparam logic [3:0] S_BLOAD  = 4'd5;
    localparam logic [3:0] S_BDIV   = 4'd6;
    localparam logic [3:0] S_RLOAD  = 4'd7;
    localparam logic [3:0] S_ROOT   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] n_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + STEP_W'(1);
                if (r_cnt == ITEM_DIV_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.batch_done ? S_BLOAD : S_IDLE;
            end
            S_BLOAD: begin
                o_cmd.load_batch = 1'b1;
                n_cnt            = '0;
                n_state          = S_BDIV;
            end
            S_BDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + STEP_W'(1);
                if (r_cnt == BATCH_DIV_LAST) begin
                    n_state = S_RLOAD;
                end
            end
            S_RLOAD: begin
                o_cmd.sqrt_load = 1'b1;
                n_cnt           = '0;
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + STEP_W'(1);
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // wait for the output register to drain
                if (w_out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/running_mean_stdev_top.sv
// Top level of the running mean and standard deviation block.
//
// Usage:
//   Samples enter on the s_axis channel, one signed fixed-point value per item.
//   Each item updates a count, a running mean and a sum of squared deviations
//   (Welford update). When the count reaches the batch size held in the cfg
//   register, one result item leaves on the m_axis channel with the mean, the
//   population standard deviation and the number of samples, and the batch
//   state clears. The cfg channel is always ready; write it while idle.
// Sequencing:
//   An item is finished before the next can be accepted: the two divisions
//   by the running count share a bit-serial divider that runs 48 steps.
//   An item that closes a batch adds a 64-step division of the squared-deviation
//   sum and a 32-step square root.
// Reset: count register returns to 1000, batch state and output valid clear.
// Back-pressure: the result waits in the output register; new samples are
//   still taken, but the next result and any sample after it wait until it drains.
module running_mean_stdev_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [23:0] sample
    // result out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [23:0] mean_value, [47:24] std_deviation,
                                          // [63:48] batch_size
    // batch size register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data        // [15:0] sample_count
);
    import rmsd_pkg::*;

    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;
    logic [SAMPLE_W-1:0] w_mean;
    logic [STD_W-1:0]    w_std;
    logic [N_W-1:0]      w_size;

    assign o_cfg_ready = 1'b1;

    rmsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rmsd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_s_axis_tdata),
        .o_mean_value    (w_mean),
        .o_std_deviation (w_std),
        .o_batch_size    (w_size)
    );

    // Result fields packed from the lowest bit up
    assign o_m_axis_tdata = {w_size, w_std, w_mean};

endmodule

// File: tb/tb.sv
// Self-checking testbench for the running mean and standard deviation block.
`timescale 1ns / 100ps

module tb;

    localparam int SETTLE_CYCLES = 170;   // one item plus a batch close, with margin
    localparam int STALL_LIMIT   = 8000;  // cycles with no item moving on any channel
    localparam int ITEM_TARGET   = 1780;  // random samples after the directed part

    // What the sample driver does next
    typedef enum logic [1:0] {
        STEP_SAMPLE,
        STEP_WRITE_COUNT,
        STEP_DRAIN
    } t_plan_kind;

    typedef struct {
        t_plan_kind  kind;
        logic [23:0] value;   // sample bits, or batch size in the low 16 bits
    } t_plan_step;

    // Expected result item, laid out as on the result bus
    typedef struct packed {
        logic [rmsd_pkg::N_W-1:0]      size;
        logic [rmsd_pkg::STD_W-1:0]    stdev;
        logic [rmsd_pkg::SAMPLE_W-1:0] mean;
    } t_batch_stats;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        smp_valid = 1'b0;
    logic        smp_ready;
    logic [23:0] smp_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [63:0] res_data;
    logic        cnt_valid = 1'b0;
    logic        cnt_ready;
    logic [15:0] cnt_data = '0;

    t_plan_step   plan_q[$];
    t_batch_stats batch_stats_q[$];
    int           fail_count = 0;

    // Predictor state: register copy and batch accumulators
    logic [15:0]        count_setting = rmsd_pkg::COUNT_RESET;
    logic [15:0]        seen;
    logic signed [23:0] mean_acc;
    logic [63:0]        dev_sq;

    running_mean_stdev_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (smp_valid),
        .o_s_axis_tready (smp_ready),
        .i_s_axis_tdata  (smp_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_valid     (cnt_valid),
        .o_cfg_ready     (cnt_ready),
        .i_cfg_data      (cnt_data)
    );

    always #5 clk = ~clk;

    // Floor square root, one bit at a time from the top
    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if ({32'd0, t} * {32'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    // Welford update for one accepted sample; queues the batch result when due
    task automatic fold_sample(input logic signed [23:0] x);
        longint       diff, mag, sq, n, term, step, m, lim;
        logic [64:0]  sum;
        logic [31:0]  root;
        t_batch_stats r;
        diff = longint'(x) - longint'(mean_acc);
        mag  = (diff < 0) ? -diff : diff;
        sq   = mag * mag;
        n    = longint'(seen) + 1;
        term = (sq / n) * (n - 1) + ((sq % n) * (n - 1)) / n;
        sum  = {1'b0, dev_sq} + {1'b0, 64'(term)};
        dev_sq = sum[64] ? '1 : sum[63:0];
        step = mag / n;
        m = longint'(mean_acc) + ((diff < 0) ? -step : step);
        if (m > 8388607)
            m = 8388607;
        if (m < -8388608)
            m = -8388608;
        mean_acc = m[23:0];
        seen = n[15:0];
        lim = (count_setting == 0) ? 1 : longint'(count_setting);
        if (n >= lim) begin
            root = floor_root(dev_sq / 64'(n));
            r.mean  = mean_acc;
            r.stdev = (root > 32'hFFFFFF) ? rmsd_pkg::STD_MAX : root[23:0];
            r.size  = n[15:0];
            batch_stats_q.push_back(r);
            seen = '0;
            mean_acc = '0;
            dev_sq = '0;
        end
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 40);
        return $urandom_range(41, 160);
    endfunction

    // Sample near a batch center, over the full range, at an edge, or in -1..1
    function automatic int draw_sample(input int center);
        int          pick, span, v;
        logic [23:0] bits;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            bits = 24'($urandom);
            return {{8{bits[23]}}, bits};
        end
        if (pick < 8) begin
            span = 1 << $urandom_range(0, 20);
            v = center + int'($urandom_range(0, 2 * span)) - span;
            if (v > 8388607)
                v = 8388607;
            if (v < -8388608)
                v = -8388608;
            return v;
        end
        if (pick == 8)
            return $urandom_range(0, 1) ? 8388607 : -8388608;
        return int'($urandom_range(0, 2)) - 1;
    endfunction

    task automatic add_sample(input int v);
        t_plan_step p;
        p.kind = STEP_SAMPLE;
        p.value = v[23:0];
        plan_q.push_back(p);
    endtask

    task automatic add_count(input int c);
        t_plan_step p;
        p.kind = STEP_WRITE_COUNT;
        p.value = {8'd0, c[15:0]};
        plan_q.push_back(p);
    endtask

    task automatic add_drain();
        t_plan_step p;
        p.kind = STEP_DRAIN;
        p.value = '0;
        plan_q.push_back(p);
    endtask

    // Sample and register driver
    int   gap_left;
    int   quiet;
    int   calm_tx;
    logic nxt_smp, nxt_cnt;

    always @(posedge clk) begin
        if (!rst_n) begin
            smp_valid <= 1'b0;
            cnt_valid <= 1'b0;
            gap_left = 0;
            quiet = 0;
            calm_tx = 0;
        end else begin
            nxt_smp = smp_valid;
            nxt_cnt = cnt_valid;
            if (calm_tx > 0)
                calm_tx--;
            // handshakes completed at this edge
            if (smp_valid && smp_ready) begin
                fold_sample(smp_data);
                nxt_smp = 1'b0;
                quiet = 0;
            end else if (batch_stats_q.size() != 0) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (cnt_valid && cnt_ready) begin
                count_setting = cnt_data;
                nxt_cnt = 1'b0;
            end
            // next step of the plan
            if (!nxt_smp && !nxt_cnt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (plan_q.size() != 0) begin
                    case (plan_q[0].kind)
                        STEP_SAMPLE: begin
                            nxt_smp = 1'b1;
                            smp_data <= plan_q[0].value;
                            void'(plan_q.pop_front());
                            if (calm_tx == 0 && $urandom_range(0, 49) == 0)
                                calm_tx = $urandom_range(300, 1000);
                            gap_left = (calm_tx > 0) ? 0 : idle_len();
                        end
                        STEP_WRITE_COUNT: begin
                            // block must be idle before the register moves
                            if (quiet >= SETTLE_CYCLES) begin
                                nxt_cnt = 1'b1;
                                cnt_data <= plan_q[0].value[15:0];
                                void'(plan_q.pop_front());
                            end
                        end
                        STEP_DRAIN: begin
                            if (batch_stats_q.size() == 0)
                                void'(plan_q.pop_front());
                        end
                        default: void'(plan_q.pop_front());
                    endcase
                end
            end
            smp_valid <= nxt_smp;
            cnt_valid <= nxt_cnt;
        end
    end

    // Result receiver: random stalls, with calm stretches
    int stall_left;
    int calm_rx;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            stall_left = 0;
            calm_rx = 0;
        end else begin
            if (calm_rx > 0)
                calm_rx--;
            else if ($urandom_range(0, 499) == 0)
                calm_rx = $urandom_range(300, 1000);
            if (stall_left == 0 && calm_rx == 0 && $urandom_range(0, 9) == 0)
                stall_left = idle_len();
            res_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Result checker
    t_batch_stats want;

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            if (batch_stats_q.size() == 0) begin
                fail_count++;
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, res_data);
            end else begin
                want = batch_stats_q.pop_front();
                if (res_data[23:0] !== want.mean) begin
                    fail_count++;
                    $display("%0t: mean_value expected %0d, got %0d", $time,
                             $signed(want.mean), $signed(res_data[23:0]));
                end
                if (res_data[47:24] !== want.stdev) begin
                    fail_count++;
                    $display("%0t: std_deviation expected %0d, got %0d", $time,
                             want.stdev, res_data[47:24]);
                end
                if (res_data[63:48] !== want.size) begin
                    fail_count++;
                    $display("%0t: batch_size expected %0d, got %0d", $time,
                             want.size, res_data[63:48]);
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((smp_valid && smp_ready) || (res_valid && res_ready)
                    || (cnt_valid && cnt_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus plan and end of run
    int sent, cnt, eff, batches, center, extra;

    initial begin
        seen = '0;
        mean_acc = '0;
        dev_sq = '0;

        // directed: edges under the reset batch size of 1000
        add_sample(0);
        add_sample(8388607);
        add_sample(-8388608);
        add_sample(1);
        add_sample(-1);
        // zero size acts as one and cuts the open batch short
        add_count(0);
        add_sample(8388607);
        add_sample(-8388608);
        add_sample(0);
        add_count(1);
        add_sample(5592405);
        add_sample(-2796203);
        // widest deviation in a batch of two
        add_count(2);
        add_sample(-8388608);
        add_sample(8388607);
        add_sample(8388607);
        add_sample(-8388608);
        add_drain();
        // largest size, then lowered mid-batch
        add_count(65535);
        add_sample(123456);
        add_sample(-654321);
        add_sample(7);
        add_count(3);
        add_sample(42);
        add_count(4);
        add_sample(-1);
        add_sample(1);
        add_sample(-1);
        add_sample(1);

        // random phases: a batch size, whole batches, sometimes a partial one
        sent = 0;
        while (sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       cnt = 0;
                1, 2:    cnt = 1;
                3, 4, 5: cnt = $urandom_range(2, 6);
                6, 7:    cnt = $urandom_range(7, 40);
                default: cnt = $urandom_range(41, 250);
            endcase
            add_count(cnt);
            eff = (cnt == 0) ? 1 : cnt;
            batches = (eff > 40) ? 1 : $urandom_range(1, 4);
            center = int'($urandom_range(0, 16777215)) - 8388608;
            for (int b = 0; b < batches; b++) begin
                for (int i = 0; i < eff; i++) begin
                    add_sample(draw_sample(center));
                    sent++;
                    if ($urandom_range(0, 199) == 0)
                        add_drain();
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                extra = $urandom_range(1, (eff > 20) ? 20 : eff);
                for (int i = 0; i < extra; i++) begin
                    add_sample(draw_sample(center));
                    sent++;
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (plan_q.size() != 0 || smp_valid || cnt_valid)
            @(posedge clk);
        while (batch_stats_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (batch_stats_q.size() != 0) begin
            fail_count++;
            $display("%0t: %0d results still expected, got none", $time,
                     batch_stats_q.size());
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rmsd_pkg.sv
hw/rtl/rmsd_div.sv
hw/rtl/rmsd_sqrt.sv
hw/rtl/rmsd_dp.sv
hw/rtl/rmsd_ctrl.sv
hw/rtl/running_mean_stdev_top.sv
tb/tb.sv
